@@ sv/ray_triangle_intersect_assert.svh @@
// assertion macros for the ray and triangle intersection block
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// same-cycle implication
`define RTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rti_pkg.sv @@
// shared types, constants, saturating helpers and microprogram of the intersect block
`timescale 1ns / 1ps
package rti_pkg;
	localparam int VW = 32;
	localparam int AW = 7;
	localparam int RF_DEPTH = 128;
	localparam int PCW = 8;
	localparam int TOLW = 16;
	localparam int MATW = 16;

	typedef logic [AW-1:0] raddr_t;
	typedef logic signed [VW-1:0] val_t;

	localparam val_t MAXV = 32'sh7fff_ffff;
	localparam val_t MINV = 32'sh8000_0000;
	localparam val_t ONE = 32'sh0001_0000;
	localparam logic [TOLW-1:0] TOL_RESET = 16'd66;

	typedef enum logic [1:0] {K_VTX, K_TEX, K_ATTR, K_CAST} kind_t;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQ0, OP_SQA, OP_SQRT,
		OP_LE0, OP_DEV, OP_TOL, OP_RNG, OP_SELN, OP_DONE
	} op_t;

	typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_FETCH, ST_EXEC, ST_MULW, ST_ITER} state_t;

	typedef struct packed {
		op_t op;
		raddr_t dst;
		raddr_t a;
		raddr_t b;
	} instr_t;

	typedef struct packed {
		logic go;
		logic root;
	} iter_ctl_t;

	// register file map
	localparam raddr_t R_P0 = 7'd0;
	localparam raddr_t R_P1 = 7'd3;
	localparam raddr_t R_P2 = 7'd6;
	localparam raddr_t R_N0 = 7'd9;
	localparam raddr_t R_T0 = 7'd18;
	localparam raddr_t R_O = 7'd24;
	localparam raddr_t R_D = 7'd27;
	localparam raddr_t R_E1 = 7'd30;
	localparam raddr_t R_E2 = 7'd33;
	localparam raddr_t R_NN = 7'd36;
	localparam raddr_t R_DEN = 7'd39;
	localparam raddr_t R_NOM = 7'd40;
	localparam raddr_t R_TT = 7'd41;
	localparam raddr_t R_TA = 7'd42;
	localparam raddr_t R_TB = 7'd43;
	localparam raddr_t R_P = 7'd44;
	localparam raddr_t R_E3 = 7'd47;
	localparam raddr_t R_E4 = 7'd50;
	localparam raddr_t R_AA = 7'd53;
	localparam raddr_t R_C = 7'd54;
	localparam raddr_t R_W = 7'd57;
	localparam raddr_t R_SUM = 7'd60;
	localparam raddr_t R_NV = 7'd61;
	localparam raddr_t R_L = 7'd64;
	localparam raddr_t R_NI = 7'd65;
	localparam raddr_t R_FN = 7'd68;
	localparam raddr_t R_TU = 7'd71;
	localparam raddr_t R_TV = 7'd72;
	localparam raddr_t R_X1 = 7'd73;
	localparam raddr_t R_X2 = 7'd74;
	localparam raddr_t R_DV = 7'd75;

	function automatic val_t sat_add(input val_t a, input val_t b);
		logic signed [VW:0] s;
		s = {a[VW-1], a} + {b[VW-1], b};
		if (s[VW] != s[VW-1]) return s[VW] ? MINV : MAXV;
		return s[VW-1:0];
	endfunction

	function automatic val_t sat_sub(input val_t a, input val_t b);
		logic signed [VW:0] s;
		s = {a[VW-1], a} - {b[VW-1], b};
		if (s[VW] != s[VW-1]) return s[VW] ? MINV : MAXV;
		return s[VW-1:0];
	endfunction

	function automatic logic [VW-1:0] mag(input val_t x);
		return x[VW-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic instr_t mk(input op_t op, input raddr_t d, input raddr_t a,
			input raddr_t b);
		instr_t r;
		r.op = op;
		r.dst = d;
		r.a = a;
		r.b = b;
		return r;
	endfunction

	function automatic instr_t cross_i(input logic [3:0] k, input raddr_t a, input raddr_t b,
			input raddr_t o);
		instr_t r;
		case (k)
			4'd0: r = mk(OP_MUL, R_X1, a + 7'd1, b + 7'd2);
			4'd1: r = mk(OP_MUL, R_X2, a + 7'd2, b + 7'd1);
			4'd2: r = mk(OP_SUB, o, R_X1, R_X2);
			4'd3: r = mk(OP_MUL, R_X1, a + 7'd2, b);
			4'd4: r = mk(OP_MUL, R_X2, a, b + 7'd2);
			4'd5: r = mk(OP_SUB, o + 7'd1, R_X1, R_X2);
			4'd6: r = mk(OP_MUL, R_X1, a, b + 7'd1);
			4'd7: r = mk(OP_MUL, R_X2, a + 7'd1, b);
			4'd8: r = mk(OP_SUB, o + 7'd2, R_X1, R_X2);
			default: r = mk(OP_DONE, R_X1, R_X1, R_X1);
		endcase
		return r;
	endfunction

	function automatic instr_t dot_i(input logic [3:0] k, input raddr_t a, input raddr_t b,
			input raddr_t o);
		instr_t r;
		case (k)
			4'd0: r = mk(OP_MUL, R_X1, a, b);
			4'd1: r = mk(OP_MUL, R_X2, a + 7'd1, b + 7'd1);
			4'd2: r = mk(OP_ADD, R_X1, R_X1, R_X2);
			4'd3: r = mk(OP_MUL, R_X2, a + 7'd2, b + 7'd2);
			4'd4: r = mk(OP_ADD, o, R_X1, R_X2);
			default: r = mk(OP_DONE, R_X1, R_X1, R_X1);
		endcase
		return r;
	endfunction

	function automatic instr_t len_i(input logic [3:0] k, input raddr_t a, input raddr_t o);
		instr_t r;
		case (k)
			4'd0: r = mk(OP_SQ0, o, a, a);
			4'd1: r = mk(OP_SQA, o, a + 7'd1, a + 7'd1);
			4'd2: r = mk(OP_SQA, o, a + 7'd2, a + 7'd2);
			4'd3: r = mk(OP_SQRT, o, a, a);
			default: r = mk(OP_DONE, R_X1, R_X1, R_X1);
		endcase
		return r;
	endfunction

	function automatic instr_t interp_i(input logic [3:0] k, input raddr_t base,
			input raddr_t stride, input raddr_t o);
		instr_t r;
		case (k)
			4'd0: r = mk(OP_MUL, R_X1, base, R_W);
			4'd1: r = mk(OP_MUL, R_X2, base + stride, R_W + 7'd1);
			4'd2: r = mk(OP_ADD, R_X1, R_X1, R_X2);
			4'd3: r = mk(OP_MUL, R_X2, base + stride + stride, R_W + 7'd2);
			4'd4: r = mk(OP_ADD, o, R_X1, R_X2);
			default: r = mk(OP_DONE, R_X1, R_X1, R_X1);
		endcase
		return r;
	endfunction

	// cast microprogram
	function automatic instr_t prog(input logic [PCW-1:0] pc);
		instr_t r;
		logic [PCW-1:0] k;
		r = mk(OP_DONE, R_X1, R_X1, R_X1);
		k = '0;
		case (pc) inside
			[0:2]: begin
				k = pc;
				r = mk(OP_SUB, R_E1 + k[6:0], R_P1 + k[6:0], R_P0 + k[6:0]);
			end
			[3:5]: begin
				k = pc - 8'd3;
				r = mk(OP_SUB, R_E2 + k[6:0], R_P2 + k[6:0], R_P0 + k[6:0]);
			end
			[6:14]: begin
				k = pc - 8'd6;
				r = cross_i(k[3:0], R_E1, R_E2, R_NN);
			end
			[15:19]: begin
				k = pc - 8'd15;
				r = dot_i(k[3:0], R_NN, R_D, R_DEN);
			end
			[20:24]: begin
				k = pc - 8'd20;
				r = dot_i(k[3:0], R_NN, R_P0, R_TA);
			end
			[25:29]: begin
				k = pc - 8'd25;
				r = dot_i(k[3:0], R_NN, R_O, R_TB);
			end
			[30:30]: r = mk(OP_SUB, R_NOM, R_TA, R_TB);
			[31:31]: r = mk(OP_DIV, R_TT, R_NOM, R_DEN);
			[32:32]: r = mk(OP_LE0, R_TT, R_TT, R_TT);
			[33:38]: begin
				k = pc - 8'd33;
				if (!k[0]) begin
					r = mk(OP_MUL, R_X1, R_D + {5'd0, k[2:1]}, R_TT);
				end else begin
					r = mk(OP_ADD, R_P + {5'd0, k[2:1]}, R_O + {5'd0, k[2:1]}, R_X1);
				end
			end
			[39:41]: begin
				k = pc - 8'd39;
				r = mk(OP_SUB, R_E3 + k[6:0], R_P1 + k[6:0], R_P + k[6:0]);
			end
			[42:44]: begin
				k = pc - 8'd42;
				r = mk(OP_SUB, R_E4 + k[6:0], R_P2 + k[6:0], R_P + k[6:0]);
			end
			[45:48]: begin
				k = pc - 8'd45;
				r = len_i(k[3:0], R_NN, R_AA);
			end
			[49:57]: begin
				k = pc - 8'd49;
				r = cross_i(k[3:0], R_E3, R_E4, R_C);
			end
			[58:61]: begin
				k = pc - 8'd58;
				r = len_i(k[3:0], R_C, R_DV);
			end
			[62:62]: r = mk(OP_DIV, R_W, R_DV, R_AA);
			[63:71]: begin
				k = pc - 8'd63;
				r = cross_i(k[3:0], R_E4, R_E2, R_C);
			end
			[72:75]: begin
				k = pc - 8'd72;
				r = len_i(k[3:0], R_C, R_DV);
			end
			[76:76]: r = mk(OP_DIV, R_W + 7'd1, R_DV, R_AA);
			[77:85]: begin
				k = pc - 8'd77;
				r = cross_i(k[3:0], R_E1, R_E3, R_C);
			end
			[86:89]: begin
				k = pc - 8'd86;
				r = len_i(k[3:0], R_C, R_DV);
			end
			[90:90]: r = mk(OP_DIV, R_W + 7'd2, R_DV, R_AA);
			[91:91]: r = mk(OP_ADD, R_SUM, R_W, R_W + 7'd1);
			[92:92]: r = mk(OP_ADD, R_SUM, R_SUM, R_W + 7'd2);
			[93:93]: r = mk(OP_DEV, R_DV, R_SUM, R_SUM);
			[94:94]: r = mk(OP_TOL, R_DV, R_DV, R_DV);
			[95:97]: begin
				k = pc - 8'd95;
				r = mk(OP_RNG, R_W, R_W + k[6:0], R_W);
			end
			[98:102]: begin
				k = pc - 8'd98;
				r = interp_i(k[3:0], R_N0, 7'd3, R_NI);
			end
			[103:107]: begin
				k = pc - 8'd103;
				r = interp_i(k[3:0], R_N0 + 7'd1, 7'd3, R_NI + 7'd1);
			end
			[108:112]: begin
				k = pc - 8'd108;
				r = interp_i(k[3:0], R_N0 + 7'd2, 7'd3, R_NI + 7'd2);
			end
			[113:115]: begin
				k = pc - 8'd113;
				r = mk(OP_SELN, R_NV + k[6:0], R_NI + k[6:0], R_NN + k[6:0]);
			end
			[116:119]: begin
				k = pc - 8'd116;
				r = len_i(k[3:0], R_NV, R_L);
			end
			[120:122]: begin
				k = pc - 8'd120;
				r = mk(OP_DIV, R_FN + k[6:0], R_NV + k[6:0], R_L);
			end
			[123:127]: begin
				k = pc - 8'd123;
				r = interp_i(k[3:0], R_T0, 7'd2, R_TU);
			end
			[128:132]: begin
				k = pc - 8'd128;
				r = interp_i(k[3:0], R_T0 + 7'd1, 7'd2, R_TV);
			end
			default: r = mk(OP_DONE, R_X1, R_X1, R_X1);
		endcase
		return r;
	endfunction
endpackage

@@ sv/rti_regfile.sv @@
// two-read one-write register file with registered read data
`timescale 1ns / 1ps
module rti_regfile (
	input  logic                clk,
	input  logic                we,
	input  rti_pkg::raddr_t     waddr,
	input  rti_pkg::val_t       wdata,
	input  rti_pkg::raddr_t     raddr_a,
	input  rti_pkg::raddr_t     raddr_b,
	output rti_pkg::val_t       rdata_a,
	output rti_pkg::val_t       rdata_b
);
	rti_pkg::val_t mem [rti_pkg::RF_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

@@ sv/rti_iter.sv @@
// shared bit-serial divider and square root unit
`timescale 1ns / 1ps
module rti_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  rti_pkg::iter_ctl_t  ctl,
	input  rti_pkg::val_t       opa,
	input  rti_pkg::val_t       opb,
	input  logic [63:0]         rad,
	output logic                done,
	output rti_pkg::val_t       result
);
	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        root_mode_q;
	logic        neg_q;
	logic        dz_q;
	logic [31:0] d_q;
	logic [63:0] sh_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [32:0] dv_rem;
	logic        dv_ge;
	logic [35:0] sq_rem;
	logic [35:0] sq_trial;
	logic        sq_ge;
	logic [47:0] quo;

	assign dv_rem = {rem_q[31:0], sh_q[63]};
	assign dv_ge = dv_rem >= {1'b0, d_q};
	assign sq_rem = {rem_q[33:0], sh_q[63:62]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge = sq_rem >= sq_trial;
	assign quo = sh_q[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.go) begin
				run_q <= 1'b1;
				cnt_q <= ctl.root ? 6'd31 : 6'd47;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			root_mode_q <= ctl.root;
			neg_q <= opa[31] ^ opb[31];
			dz_q <= (opb == '0);
			d_q <= rti_pkg::mag(opb);
			sh_q <= ctl.root ? rad : {rti_pkg::mag(opa), 32'd0};
			rem_q <= '0;
			root_q <= '0;
		end else if (run_q) begin
			if (root_mode_q) begin
				sh_q <= {sh_q[61:0], 2'b00};
				rem_q <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
				root_q <= {root_q[30:0], sq_ge};
			end else begin
				sh_q <= {sh_q[62:0], dv_ge};
				rem_q <= {3'b000, dv_ge ? (dv_rem - {1'b0, d_q}) : dv_rem};
			end
		end
	end

	always_comb begin
		if (root_mode_q) begin
			result = root_q[31] ? rti_pkg::MAXV : root_q;
		end else if (dz_q) begin
			result = '0;
		end else if (quo[47:31] != '0) begin
			result = neg_q ? rti_pkg::MINV : rti_pkg::MAXV;
		end else begin
			result = neg_q ? (32'd0 - quo[31:0]) : quo[31:0];
		end
	end

	assign done = done_q;
endmodule

@@ sv/ray_triangle_intersect.sv @@
// top level: ray and triangle intersection sequencer with shared arithmetic
//
// usage: a request is taken on a rising edge with start high and busy low.
// kind selects the request: vertex position and normal, texture coordinate,
// triangle attributes, or a ray cast. attribute requests take effect at once
// and leave busy low. vertex and texture loads write the register file one
// word a cycle; a load to slot three is dropped.
// a cast writes the ray and then runs a microprogram on one saturating adder,
// one 32x32 multiplier and one bit-serial divide/root unit.
// each microinstruction passes a fetch and an execute state; a multiply then
// waits in a multiply state and a divide or square root in an iterate state.
// a full hit raises done at the end of the microprogram, an early miss sooner;
// most of a cast goes to the divide and root unit: seven divides and five roots.
// every cast ends with done high for exactly one cycle; hit tells a hit from a
// miss, and on a miss all other result ports read zero. the receiver cannot
// stall the block. the next request may be taken in the cycle done is high.
// cfg_we writes sum_tolerance; the user must use it only while busy is low;
// the block does not enforce this. reset clears the attributes, the tolerance
// (to 66) and the sequencer; vertex data is undefined until loaded.
`timescale 1ns / 1ps
module ray_triangle_intersect (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [1:0]          slot,
	input  logic signed [31:0]  a_x,
	input  logic signed [31:0]  a_y,
	input  logic signed [31:0]  a_z,
	input  logic signed [31:0]  b_x,
	input  logic signed [31:0]  b_y,
	input  logic signed [31:0]  b_z,
	input  logic [15:0]         material_in,
	input  logic                use_normals,
	input  logic                use_tex,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	output logic                done,
	output logic                hit,
	output logic [30:0]         distance,
	output logic signed [31:0]  hit_x,
	output logic signed [31:0]  hit_y,
	output logic signed [31:0]  hit_z,
	output logic signed [31:0]  normal_x,
	output logic signed [31:0]  normal_y,
	output logic signed [31:0]  normal_z,
	output logic signed [31:0]  tex_u,
	output logic signed [31:0]  tex_v,
	output logic                tex_valid,
	output logic [15:0]         material_out
);
	rti_pkg::state_t state_q, state_d;
	logic [rti_pkg::PCW-1:0] pc_q;
	logic [2:0] ld_q;
	rti_pkg::kind_t kind_q;
	logic [1:0] slot_q;
	rti_pkg::val_t in_q [6];
	logic [rti_pkg::TOLW-1:0] tol_q;
	logic [rti_pkg::MATW-1:0] mat_q;
	logic nen_q;
	logic ten_q;
	logic [63:0] prod_q;
	logic pneg_q;
	logic [63:0] acc_q;
	logic hit_q;
	logic done_q;
	rti_pkg::val_t t_q, px_q, py_q, pz_q, nx_q, ny_q, nz_q, tu_q, tv_q;

	rti_pkg::instr_t instr;
	rti_pkg::val_t rd_a, rd_b;
	logic wr_en;
	rti_pkg::raddr_t wr_addr;
	rti_pkg::val_t wr_data;
	logic pc_inc, ld_inc, emit, emit_hit, mul_go, acc_ld, acc_add;
	rti_pkg::iter_ctl_t iter_ctl;
	logic iter_done;
	rti_pkg::val_t iter_res;
	logic accept;
	logic ld_last;
	rti_pkg::raddr_t ld_addr, s3, ld7;
	logic [31:0] mul_a, mul_b;
	logic [47:0] pm;
	rti_pkg::val_t mul_res;
	rti_pkg::val_t dev1, dev;
	rti_pkg::val_t tolv;

	assign busy = (state_q != rti_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign instr = rti_pkg::prog(pc_q);

	rti_regfile u_rf (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (instr.a),
		.raddr_b (instr.b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	rti_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (iter_ctl),
		.opa    (rd_a),
		.opb    (rd_b),
		.rad    (acc_q),
		.done   (iter_done),
		.result (iter_res)
	);

	// load addressing
	assign s3 = 7'({slot_q, 1'b0}) + 7'(slot_q);
	assign ld7 = 7'(ld_q);
	always_comb begin
		case (kind_q)
			rti_pkg::K_TEX: ld_addr = rti_pkg::R_T0 + 7'({slot_q, 1'b0}) + ld7;
			rti_pkg::K_VTX: ld_addr = (ld_q < 3'd3) ? (rti_pkg::R_P0 + s3 + ld7)
					: (rti_pkg::R_N0 + s3 + ld7 - 7'd3);
			default: ld_addr = rti_pkg::R_O + ld7;
		endcase
	end
	assign ld_last = (kind_q == rti_pkg::K_TEX) ? (ld_q == 3'd1) : (ld_q == 3'd5);

	// multiply result, truncated toward zero and saturated
	assign mul_a = rti_pkg::mag(rd_a);
	assign mul_b = (instr.op == rti_pkg::OP_SQ0 || instr.op == rti_pkg::OP_SQA)
			? rti_pkg::mag(rd_a) : rti_pkg::mag(rd_b);
	assign pm = prod_q[63:16];
	always_comb begin
		if (pm[47:31] != '0) begin
			mul_res = pneg_q ? rti_pkg::MINV : rti_pkg::MAXV;
		end else begin
			mul_res = pneg_q ? (32'd0 - pm[31:0]) : pm[31:0];
		end
	end

	assign dev1 = rti_pkg::sat_sub(rti_pkg::ONE, rd_a);
	assign dev = dev1[31] ? rti_pkg::sat_sub('0, dev1) : dev1;
	assign tolv = rti_pkg::val_t'({16'd0, tol_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rti_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		wr_en = 1'b0;
		wr_addr = instr.dst;
		wr_data = rti_pkg::sat_add(rd_a, rd_b);
		pc_inc = 1'b0;
		ld_inc = 1'b0;
		emit = 1'b0;
		emit_hit = 1'b0;
		mul_go = 1'b0;
		acc_ld = 1'b0;
		acc_add = 1'b0;
		iter_ctl = '0;
		case (state_q)
			rti_pkg::ST_IDLE: begin
				if (start) begin
					case (rti_pkg::kind_t'(kind))
						rti_pkg::K_VTX, rti_pkg::K_TEX: begin
							if (slot != 2'd3) state_d = rti_pkg::ST_LOAD;
						end
						rti_pkg::K_CAST: state_d = rti_pkg::ST_LOAD;
						default: state_d = rti_pkg::ST_IDLE;
					endcase
				end
			end
			rti_pkg::ST_LOAD: begin
				wr_en = 1'b1;
				wr_addr = ld_addr;
				wr_data = in_q[ld_q];
				ld_inc = 1'b1;
				if (ld_last) begin
					state_d = (kind_q == rti_pkg::K_CAST) ? rti_pkg::ST_FETCH
							: rti_pkg::ST_IDLE;
				end
			end
			rti_pkg::ST_FETCH: state_d = rti_pkg::ST_EXEC;
			rti_pkg::ST_EXEC: begin
				state_d = rti_pkg::ST_FETCH;
				case (instr.op)
					rti_pkg::OP_ADD: begin
						wr_en = 1'b1;
						pc_inc = 1'b1;
					end
					rti_pkg::OP_SUB: begin
						wr_en = 1'b1;
						wr_data = rti_pkg::sat_sub(rd_a, rd_b);
						pc_inc = 1'b1;
					end
					rti_pkg::OP_MUL, rti_pkg::OP_SQ0, rti_pkg::OP_SQA: begin
						mul_go = 1'b1;
						state_d = rti_pkg::ST_MULW;
					end
					rti_pkg::OP_DIV: begin
						iter_ctl.go = 1'b1;
						state_d = rti_pkg::ST_ITER;
					end
					rti_pkg::OP_SQRT: begin
						iter_ctl.go = 1'b1;
						iter_ctl.root = 1'b1;
						state_d = rti_pkg::ST_ITER;
					end
					rti_pkg::OP_LE0: begin
						if (rd_a[31] || rd_a == '0) begin
							emit = 1'b1;
							state_d = rti_pkg::ST_IDLE;
						end else begin
							pc_inc = 1'b1;
						end
					end
					rti_pkg::OP_DEV: begin
						wr_en = 1'b1;
						wr_data = dev;
						pc_inc = 1'b1;
					end
					rti_pkg::OP_TOL: begin
						if (!(rd_a < tolv)) begin
							emit = 1'b1;
							state_d = rti_pkg::ST_IDLE;
						end else begin
							pc_inc = 1'b1;
						end
					end
					rti_pkg::OP_RNG: begin
						if (rd_a[31] || rd_a > rti_pkg::ONE) begin
							emit = 1'b1;
							state_d = rti_pkg::ST_IDLE;
						end else begin
							pc_inc = 1'b1;
						end
					end
					rti_pkg::OP_SELN: begin
						wr_en = 1'b1;
						wr_data = nen_q ? rd_a : rd_b;
						pc_inc = 1'b1;
					end
					default: begin
						emit = 1'b1;
						emit_hit = 1'b1;
						state_d = rti_pkg::ST_IDLE;
					end
				endcase
			end
			rti_pkg::ST_MULW: begin
				pc_inc = 1'b1;
				state_d = rti_pkg::ST_FETCH;
				case (instr.op)
					rti_pkg::OP_SQ0: acc_ld = 1'b1;
					rti_pkg::OP_SQA: acc_add = 1'b1;
					default: begin
						wr_en = 1'b1;
						wr_data = mul_res;
					end
				endcase
			end
			rti_pkg::ST_ITER: begin
				if (iter_done) begin
					wr_en = 1'b1;
					wr_data = iter_res;
					pc_inc = 1'b1;
					state_d = rti_pkg::ST_FETCH;
				end
			end
			default: state_d = rti_pkg::ST_IDLE;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			ld_q <= '0;
			kind_q <= rti_pkg::K_VTX;
			slot_q <= '0;
			tol_q <= rti_pkg::TOL_RESET;
			mat_q <= '0;
			nen_q <= 1'b0;
			ten_q <= 1'b0;
			hit_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
			if (emit) hit_q <= emit_hit;
			if (cfg_we) tol_q <= cfg_data;
			if (accept) begin
				kind_q <= rti_pkg::kind_t'(kind);
				slot_q <= slot;
				ld_q <= '0;
				pc_q <= '0;
				if (rti_pkg::kind_t'(kind) == rti_pkg::K_ATTR) begin
					mat_q <= material_in;
					nen_q <= use_normals;
					ten_q <= use_tex;
				end
			end else begin
				if (ld_inc) ld_q <= ld_q + 3'd1;
				if (pc_inc) pc_q <= pc_q + 8'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q[0] <= a_x;
			in_q[1] <= a_y;
			in_q[2] <= a_z;
			in_q[3] <= b_x;
			in_q[4] <= b_y;
			in_q[5] <= b_z;
		end
		if (mul_go) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
			pneg_q <= rd_a[31] ^ rd_b[31];
		end
		if (acc_ld) acc_q <= prod_q;
		if (acc_add) acc_q <= acc_q + prod_q;
		if (wr_en) begin
			if (wr_addr == rti_pkg::R_TT) t_q <= wr_data;
			if (wr_addr == rti_pkg::R_P) px_q <= wr_data;
			if (wr_addr == rti_pkg::R_P + 7'd1) py_q <= wr_data;
			if (wr_addr == rti_pkg::R_P + 7'd2) pz_q <= wr_data;
			if (wr_addr == rti_pkg::R_FN) nx_q <= wr_data;
			if (wr_addr == rti_pkg::R_FN + 7'd1) ny_q <= wr_data;
			if (wr_addr == rti_pkg::R_FN + 7'd2) nz_q <= wr_data;
			if (wr_addr == rti_pkg::R_TU) tu_q <= wr_data;
			if (wr_addr == rti_pkg::R_TV) tv_q <= wr_data;
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign distance = hit_q ? t_q[30:0] : '0;
	assign hit_x = hit_q ? px_q : '0;
	assign hit_y = hit_q ? py_q : '0;
	assign hit_z = hit_q ? pz_q : '0;
	assign normal_x = hit_q ? nx_q : '0;
	assign normal_y = hit_q ? ny_q : '0;
	assign normal_z = hit_q ? nz_q : '0;
	assign tex_valid = hit_q && ten_q;
	assign tex_u = (hit_q && ten_q) ? tu_q : '0;
	assign tex_v = (hit_q && ten_q) ? tv_q : '0;
	assign material_out = hit_q ? mat_q : '0;
endmodule

@@ sv/rti_checker.sv @@
// port-level checker for the intersect block, bound to the top level
`timescale 1ns / 1ps
`include "ray_triangle_intersect_assert.svh"
module rti_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic [1:0]          kind,
	input logic                done,
	input logic                hit,
	input logic [30:0]         distance,
	input logic                tex_valid,
	input logic [15:0]         material_out
);
	`RTI_ASSERT_NXT(a_done_single, clk, arst_n, done, !done, "done held for two cycles")
	`RTI_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "done while busy")
	`RTI_ASSERT_NXT(a_cast_busy, clk, arst_n, start && !busy && kind == rti_pkg::K_CAST, busy, "cast request not taken")
	`RTI_ASSERT_NXT(a_attr_quiet, clk, arst_n, start && !busy && kind == rti_pkg::K_ATTR, !busy && !done, "attribute request started work")
	`RTI_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !hit, distance == 31'd0 && !tex_valid && material_out == 16'd0, "miss with nonzero fields")
endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

@@ dv/tb.sv @@
// self-checking testbench for the ray and triangle intersection block
`timescale 1ns / 1ps
module tb;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam longint QONE = 64'sd65536;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		rti_pkg::kind_t kind;
		logic [1:0] slot;
		logic signed [31:0] a [3];
		logic signed [31:0] b [3];
		logic [15:0] material;
		logic use_normals;
		logic use_tex;
	} request_t;

	typedef struct packed {
		logic hit;
		logic [30:0] distance;
		logic signed [31:0] hx, hy, hz;
		logic signed [31:0] nx, ny, nz;
		logic signed [31:0] tu, tv;
		logic tex_valid;
		logic [15:0] material;
	} cast_result_t;

	class intersect_scoreboard;
		longint pos [9];
		longint nrm [9];
		longint uv [6];
		logic [15:0] material;
		bit normals_on;
		bit tex_on;
		logic [15:0] tolerance;
		cast_result_t pending_hits [$];
		int mismatches;
		int casts;
		int hits;
		int loads;

		function new();
			foreach (pos[i]) pos[i] = 0;
			foreach (nrm[i]) nrm[i] = 0;
			foreach (uv[i]) uv[i] = 0;
			material = '0;
			normals_on = 0;
			tex_on = 0;
			tolerance = rti_pkg::TOL_RESET;
			mismatches = 0;
			casts = 0;
			hits = 0;
			loads = 0;
		endfunction

		function longint clampq(longint x);
			if (x > QMAX) return QMAX;
			if (x < QMIN) return QMIN;
			return x;
		endfunction

		function longint absq(longint x);
			return x < 0 ? -x : x;
		endfunction

		function longint qadd(longint a, longint b);
			return clampq(a + b);
		endfunction

		function longint qsub(longint a, longint b);
			return clampq(a - b);
		endfunction

		function longint qmul(longint a, longint b);
			longint m;
			m = (absq(a) * absq(b)) >> 16;
			return clampq(((a < 0) != (b < 0)) ? -m : m);
		endfunction

		function longint qdiv(longint a, longint b);
			longint m;
			if (b == 0) return 0;
			m = (absq(a) << 16) / absq(b);
			return clampq(((a < 0) != (b < 0)) ? -m : m);
		endfunction

		function longint qlen(longint x, longint y, longint z);
			logic [127:0] s, cand, m0, m1, m2;
			logic [127:0] root;
			m0 = 128'(absq(x));
			m1 = 128'(absq(y));
			m2 = 128'(absq(z));
			s = m0 * m0 + m1 * m1 + m2 * m2;
			root = '0;
			for (int bit_i = 33; bit_i >= 0; bit_i--) begin
				cand = root | (128'd1 << bit_i);
				if (cand * cand <= s) root = cand;
			end
			return (root > QMAX) ? QMAX : longint'(root);
		endfunction

		function void vsub(input longint a [3], input longint b [3], output longint o [3]);
			for (int i = 0; i < 3; i++) o[i] = qsub(a[i], b[i]);
		endfunction

		function void vcross(input longint a [3], input longint b [3], output longint o [3]);
			o[0] = qsub(qmul(a[1], b[2]), qmul(a[2], b[1]));
			o[1] = qsub(qmul(a[2], b[0]), qmul(a[0], b[2]));
			o[2] = qsub(qmul(a[0], b[1]), qmul(a[1], b[0]));
		endfunction

		function longint vdot(input longint a [3], input longint b [3]);
			return qadd(qadd(qmul(a[0], b[0]), qmul(a[1], b[1])), qmul(a[2], b[2]));
		endfunction

		function cast_result_t trace(request_t r);
			cast_result_t res;
			longint o [3], d [3], v0 [3], v1 [3], v2 [3];
			longint e1 [3], e2 [3], e3 [3], e4 [3], n [3], p [3], c [3], nv [3];
			longint w [3];
			longint denom, nom, t, area, sum, dev, len;
			res = '0;
			for (int i = 0; i < 3; i++) begin
				o[i] = r.a[i];
				d[i] = r.b[i];
				v0[i] = pos[i];
				v1[i] = pos[3 + i];
				v2[i] = pos[6 + i];
			end
			vsub(v1, v0, e1);
			vsub(v2, v0, e2);
			vcross(e1, e2, n);
			denom = vdot(n, d);
			if (denom == 0) return res;
			nom = qsub(vdot(n, v0), vdot(n, o));
			t = qdiv(nom, denom);
			if (t <= 0) return res;
			for (int i = 0; i < 3; i++) p[i] = qadd(o[i], qmul(d[i], t));
			vsub(v1, p, e3);
			vsub(v2, p, e4);
			area = qlen(n[0], n[1], n[2]);
			if (area == 0) return res;
			vcross(e3, e4, c);
			w[0] = qdiv(qlen(c[0], c[1], c[2]), area);
			vcross(e4, e2, c);
			w[1] = qdiv(qlen(c[0], c[1], c[2]), area);
			vcross(e1, e3, c);
			w[2] = qdiv(qlen(c[0], c[1], c[2]), area);
			sum = qadd(qadd(w[0], w[1]), w[2]);
			dev = qsub(QONE, sum);
			if (dev < 0) dev = qsub(0, dev);
			if (!(dev < longint'(tolerance))) return res;
			for (int i = 0; i < 3; i++)
				if (w[i] < 0 || w[i] > QONE) return res;
			for (int i = 0; i < 3; i++)
				nv[i] = normals_on ? qadd(qadd(qmul(nrm[i], w[0]), qmul(nrm[3 + i], w[1])),
					qmul(nrm[6 + i], w[2])) : n[i];
			len = qlen(nv[0], nv[1], nv[2]);
			res.hit = 1'b1;
			res.distance = t[30:0];
			res.hx = p[0][31:0];
			res.hy = p[1][31:0];
			res.hz = p[2][31:0];
			if (len != 0) begin
				res.nx = 32'(qdiv(nv[0], len));
				res.ny = 32'(qdiv(nv[1], len));
				res.nz = 32'(qdiv(nv[2], len));
			end
			if (tex_on) begin
				res.tu = 32'(qadd(qadd(qmul(uv[0], w[0]), qmul(uv[2], w[1])),
					qmul(uv[4], w[2])));
				res.tv = 32'(qadd(qadd(qmul(uv[1], w[0]), qmul(uv[3], w[1])),
					qmul(uv[5], w[2])));
				res.tex_valid = 1'b1;
			end
			res.material = material;
			return res;
		endfunction

		function void note_request(request_t r);
			cast_result_t res;
			case (r.kind)
				rti_pkg::K_VTX: if (r.slot != 2'd3) begin
					loads++;
					for (int i = 0; i < 3; i++) begin
						pos[r.slot * 3 + i] = r.a[i];
						nrm[r.slot * 3 + i] = r.b[i];
					end
				end
				rti_pkg::K_TEX: if (r.slot != 2'd3) begin
					loads++;
					uv[r.slot * 2] = r.a[0];
					uv[r.slot * 2 + 1] = r.a[1];
				end
				rti_pkg::K_ATTR: begin
					loads++;
					material = r.material;
					normals_on = r.use_normals;
					tex_on = r.use_tex;
				end
				default: begin
					res = trace(r);
					casts++;
					if (res.hit) hits++;
					pending_hits.push_back(res);
				end
			endcase
		endfunction

		function void check_result(cast_result_t act);
			cast_result_t exp_r;
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", act);
				return;
			end
			exp_r = pending_hits.pop_front();
			if (act !== exp_r) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch at %0t", $realtime);
					$display("  exp %p", exp_r);
					$display("  act %p", act);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] kind;
	logic [1:0] slot;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
	logic [15:0] material_in;
	logic use_normals, use_tex;
	logic cfg_we;
	logic [15:0] cfg_data;
	logic done, hit, tex_valid;
	logic [30:0] distance;
	logic signed [31:0] hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, tex_u, tex_v;
	logic [15:0] material_out;

	intersect_scoreboard sb;
	int idle_cycles;
	int sent;
	bit burst;
	int cfg_writes;

	ray_triangle_intersect i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind), .slot(slot),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.material_in(material_in), .use_normals(use_normals), .use_tex(use_tex),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .hit(hit),
		.distance(distance), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.tex_u(tex_u), .tex_v(tex_v), .tex_valid(tex_valid), .material_out(material_out)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({hit, distance, hit_x, hit_y, hit_z, normal_x, normal_y,
				normal_z, tex_u, tex_v, tex_valid, material_out});
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic signed [31:0] rnd_q(int span);
		return $signed($urandom_range(0, 2 * span * 65536)) - span * 65536;
	endfunction

	function automatic request_t mk_req(rti_pkg::kind_t k, logic [1:0] s,
			logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
			logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz);
		request_t r;
		r.kind = k;
		r.slot = s;
		r.a[0] = ax;
		r.a[1] = ay;
		r.a[2] = az;
		r.b[0] = bx;
		r.b[1] = by;
		r.b[2] = bz;
		r.material = 16'($urandom);
		r.use_normals = 1'($urandom);
		r.use_tex = 1'($urandom);
		return r;
	endfunction

	function automatic request_t noise_req();
		return mk_req(rti_pkg::kind_t'($urandom_range(0, 3)), 2'($urandom), $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	task automatic send(request_t r);
		int gap;
		if (sent % 50 == 0) burst = ($urandom_range(0, 3) == 0);
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= r.kind;
		slot <= r.slot;
		a_x <= r.a[0];
		a_y <= r.a[1];
		a_z <= r.a[2];
		b_x <= r.b[0];
		b_y <= r.b[1];
		b_z <= r.b[2];
		material_in <= r.material;
		use_normals <= r.use_normals;
		use_tex <= r.use_tex;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		sent++;
	endtask

	task automatic set_tolerance(logic [15:0] v);
		start <= 1'b0;
		while (sb.pending_hits.size() > 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.tolerance = v;
		cfg_writes++;
	endtask

	// fresh triangle, then rays aimed at points chosen by random barycentric weights
	task automatic triangle_burst();
		request_t r;
		longint v [9];
		longint tgt [3];
		int w0, w1, w2, span;
		span = ($urandom_range(0, 7) == 0) ? 2000 : 32;
		for (int s = 0; s < 3; s++) begin
			for (int i = 0; i < 3; i++) v[s * 3 + i] = rnd_q(span);
			send(mk_req(rti_pkg::K_VTX, 2'(s), 32'(v[s * 3]), 32'(v[s * 3 + 1]),
				32'(v[s * 3 + 2]), rnd_q(1), rnd_q(1), rnd_q(1)));
			if ($urandom_range(0, 1))
				send(mk_req(rti_pkg::K_TEX, 2'(s), rnd_q(4), rnd_q(4), $urandom, $urandom,
					$urandom, $urandom));
		end
		send(mk_req(rti_pkg::K_ATTR, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom));
		repeat ($urandom_range(1, 4)) begin
			w0 = $urandom_range(0, 256);
			w1 = $urandom_range(0, 256 - w0);
			if ($urandom_range(0, 4) == 0) w1 = $urandom_range(0, 400);
			w2 = 256 - w0 - w1;
			for (int i = 0; i < 3; i++)
				tgt[i] = (v[i] * w0 + v[3 + i] * w1 + v[6 + i] * w2) / 256;
			r = mk_req(rti_pkg::K_CAST, 2'($urandom), rnd_q(32), rnd_q(32), rnd_q(32),
				0, 0, 0);
			for (int i = 0; i < 3; i++) r.b[i] = 32'(tgt[i] - longint'(r.a[i]));
			if ($urandom_range(0, 3) == 0)
				for (int i = 0; i < 3; i++) r.b[i] = r.b[i] >>> 1;
			send(r);
		end
	endtask

	initial begin
		request_t r;
		logic [15:0] tol_plan [6];
		int phase;
		sb = new();
		sent = 0;
		burst = 0;
		cfg_writes = 0;
		tol_plan = '{16'hffff, 16'd0, 16'd1, 16'd500, 16'd66, 16'd4000};
		arst_n = 1'b0;
		start = 1'b0;
		kind = '0;
		slot = '0;
		{a_x, a_y, a_z, b_x, b_y, b_z} = '0;
		material_in = '0;
		use_normals = 1'b0;
		use_tex = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: right triangle with legs of 4.0 in z = 0
		send(mk_req(rti_pkg::K_VTX, 0, 0, 0, 0, 0, 0, 32'sh10000));
		send(mk_req(rti_pkg::K_VTX, 1, 32'sh40000, 0, 0, 0, 0, 32'sh10000));
		send(mk_req(rti_pkg::K_VTX, 2, 0, 32'sh40000, 0, 0, 0, 32'sh10000));
		send(mk_req(rti_pkg::K_TEX, 0, 0, 0, 0, 0, 0, 0));
		send(mk_req(rti_pkg::K_TEX, 1, 32'sh10000, 0, 0, 0, 0, 0));
		send(mk_req(rti_pkg::K_TEX, 2, rti_pkg::MINV, rti_pkg::MAXV, 0, 0, 0, 0));
		r = mk_req(rti_pkg::K_ATTR, 0, 0, 0, 0, 0, 0, 0);
		r.material = 16'hffff;
		r.use_normals = 1'b1;
		r.use_tex = 1'b1;
		send(r);
		send(mk_req(rti_pkg::K_CAST, 0, 32'sh10000, 32'sh10000, 32'sh50000, 0, 0,
			-32'sh10000));
		send(mk_req(rti_pkg::K_CAST, 0, 32'sh50000, 32'sh50000, 32'sh50000, 0, 0,
			-32'sh10000));
		send(mk_req(rti_pkg::K_CAST, 0, 32'sh10000, 32'sh10000, 32'sh50000, 32'sh10000,
			0, 0));
		send(mk_req(rti_pkg::K_CAST, 0, 32'sh10000, 32'sh10000, 32'sh50000, 0, 0,
			32'sh10000));
		send(mk_req(rti_pkg::K_CAST, 3, rti_pkg::MAXV, rti_pkg::MINV, rti_pkg::MAXV,
			rti_pkg::MINV, rti_pkg::MAXV, rti_pkg::MINV));
		send(mk_req(rti_pkg::K_VTX, 3, rti_pkg::MAXV, rti_pkg::MAXV, rti_pkg::MAXV,
			rti_pkg::MINV, rti_pkg::MINV, rti_pkg::MINV));
		send(mk_req(rti_pkg::K_TEX, 3, rti_pkg::MAXV, rti_pkg::MINV, 0, 0, 0, 0));
		r = mk_req(rti_pkg::K_ATTR, 0, 0, 0, 0, 0, 0, 0);
		r.material = 16'h0000;
		r.use_normals = 1'b0;
		r.use_tex = 1'b0;
		send(r);
		send(mk_req(rti_pkg::K_CAST, 0, 32'sh8000, 32'sh8000, -32'sh30000, 0, 0,
			32'sh10000));
		r.use_normals = 1'b1;
		send(r);
		send(mk_req(rti_pkg::K_VTX, 0, 0, 0, 0, 0, 0, 0));
		send(mk_req(rti_pkg::K_VTX, 1, 32'sh40000, 0, 0, 0, 0, 0));
		send(mk_req(rti_pkg::K_VTX, 2, 0, 32'sh40000, 0, 0, 0, 0));
		send(mk_req(rti_pkg::K_CAST, 0, 32'sh8000, 32'sh8000, 32'sh30000, 0, 0,
			-32'sh10000));
		send(mk_req(rti_pkg::K_VTX, 2, 32'sh80000, 0, 0, 0, 0, 0));
		send(mk_req(rti_pkg::K_CAST, 0, 32'sh8000, 32'sh8000, 32'sh30000, 0, 0,
			-32'sh10000));
		send(mk_req(rti_pkg::K_VTX, 0, rti_pkg::MINV, rti_pkg::MAXV, rti_pkg::MINV,
			rti_pkg::MAXV, rti_pkg::MINV, rti_pkg::MAXV));
		send(mk_req(rti_pkg::K_CAST, 0, rti_pkg::MAXV, rti_pkg::MAXV, rti_pkg::MAXV,
			rti_pkg::MINV, rti_pkg::MINV, rti_pkg::MINV));

		// random: mostly well-formed triangles and aimed rays, some noise
		phase = 0;
		while (sent < 850) begin
			if (sent >= 120 * (phase + 1) && phase < 6) begin
				set_tolerance(phase == 5 ? 16'($urandom) : tol_plan[phase]);
				phase++;
			end
			if ($urandom_range(0, 3) == 0)
				send(noise_req());
			else
				triangle_burst();
		end
		set_tolerance(16'($urandom));

		start <= 1'b0;
		while (sb.pending_hits.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d requests: %0d loads, %0d casts of which %0d hit",
			sent, sb.loads, sb.casts, sb.hits);
		$display("tolerance rewritten %0d times, %0d mismatches", cfg_writes, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_hits.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
